// ----- hw/rtl/rckp_pkg.sv -----
`default_nettype none
package rckp_pkg;
	localparam int MAX_POSITIONS = 256;
	localparam int KMER_LEN = 8;
	localparam int TOP_MAX = 64;
	localparam int COUNT_BITS = 32;

	localparam int KMER_BITS = 2 * KMER_LEN;
	localparam int KMER_SPACE = 1 << KMER_BITS;
	localparam int POS_BITS = $clog2(MAX_POSITIONS);
	localparam int LEN_BITS = POS_BITS + 1;
	localparam int RPOS_BITS = 16;
	localparam int PC_DEPTH = MAX_POSITIONS * 5;
	localparam int PC_ABITS = $clog2(PC_DEPTH);
	localparam int TOP_BITS = $clog2(TOP_MAX + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [1:0] MODE_BASE = 2'd0;
	localparam logic [1:0] MODE_CONS = 2'd1;
	localparam logic [1:0] MODE_RANK = 2'd2;
	localparam logic [2:0] BASE_N = 3'd4;

	localparam logic [0:0] REG_MAX_LENGTH = 1'd0;
	localparam logic [0:0] REG_TOP_COUNT = 1'd1;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
			input logic [COUNT_BITS-1:0] b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	// a ranks before b: larger count, or equal count and lower code
	function automatic logic ranks_before(input logic [COUNT_BITS-1:0] ca,
			input logic [KMER_BITS-1:0] ka, input logic [COUNT_BITS-1:0] cb,
			input logic [KMER_BITS-1:0] kb);
		ranks_before = (ca > cb) || ((ca == cb) && (ka < kb));
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/rckp_ram.sv -----
`default_nettype none
module rckp_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/read_consensus_kmer_profiler.sv -----
// Read consensus and k-mer profiler.
// Input channel (in_valid/in_stall): mode 0 streams one base of a read, read_end
// on its last base; mode 1 asks for the consensus at position query_index; mode
// 2 asks for the k-mer of rank query_index. Modes 1 and 2 give one result on
// the output channel (out_valid/out_stall); modes 0 and 3 give none.
// After reset a clearing pass sweeps the k-mer histogram (65536 entries) while
// the position count memory (1280 entries) is cleared in parallel; no item is
// taken until it ends. Config writes over APB are taken at any time.
// A base reads, increments and writes back one count entry; at read end a
// complete leading k-mer free of N then has its histogram entry read and
// written back. A consensus query reads four count entries, none on a miss;
// the next item is taken only once its result is loaded into the output
// register. A rank query scans the whole histogram once per rank step, one
// entry a cycle, ending early when no further nonzero entry is left.
// A stalled result is held in the output register; the next item is still
// taken, and its own result waits until the held one is transferred.
`default_nettype none
module read_consensus_kmer_profiler
	import rckp_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire  [2:0]            paddr,
	input  wire  [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire  [1:0]            mode,
	input  wire  [2:0]            base,
	input  wire                   read_end,
	input  wire  [7:0]            query_index,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic                  hit,
	output logic [2:0]            consensus_base,
	output logic [31:0]           majority_count,
	output logic [31:0]           depth_total,
	output logic [15:0]           kmer_code,
	output logic [31:0]           kmer_hits,
	output logic [31:0]           kmer_total
);
	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_BRD    = 4'd2;
	localparam logic [3:0] ST_BWR    = 4'd3;
	localparam logic [3:0] ST_KRD    = 4'd4;
	localparam logic [3:0] ST_KWR    = 4'd5;
	localparam logic [3:0] ST_CRD    = 4'd6;
	localparam logic [3:0] ST_SCAN   = 4'd7;
	localparam logic [3:0] ST_OUT    = 4'd8;
	localparam logic [3:0] ST_CWAIT  = 4'd9;

	logic [3:0] state_q;
	logic [8:0] max_length_q;
	logic [6:0] top_count_q;

	// registers
	wire cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_MAX_LENGTH: prdata = {23'd0, max_length_q};
			REG_TOP_COUNT:  prdata = {25'd0, top_count_q};
			default:        prdata = '0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= 9'd256;
			top_count_q <= 7'd16;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAX_LENGTH)
				max_length_q <= pwdata[8:0];
			else
				top_count_q <= pwdata[6:0];
		end
	end

	// memories
	logic                  pc_we;
	logic [PC_ABITS-1:0]   pc_waddr, pc_raddr;
	logic [COUNT_BITS-1:0] pc_wdata, pc_rdata;
	logic                  kh_we;
	logic [KMER_BITS-1:0]  kh_waddr, kh_raddr;
	logic [COUNT_BITS-1:0] kh_wdata, kh_rdata;

	rckp_ram #(.DEPTH(PC_DEPTH), .WIDTH(COUNT_BITS)) u_pos_ram (
		.clk(clk), .we(pc_we), .waddr(pc_waddr), .wdata(pc_wdata),
		.raddr(pc_raddr), .rdata(pc_rdata));
	rckp_ram #(.DEPTH(KMER_SPACE), .WIDTH(COUNT_BITS)) u_kmer_ram (
		.clk(clk), .we(kh_we), .waddr(kh_waddr), .wdata(kh_wdata),
		.raddr(kh_raddr), .rdata(kh_rdata));

	logic [RPOS_BITS-1:0]  rpos_q;
	logic [KMER_BITS-1:0]  kshift_q;
	logic                  khasn_q;
	logic [LEN_BITS-1:0]   obs_len_q;
	logic [COUNT_BITS-1:0] ksum_q;

	// item latch
	logic [2:0]            code_q;
	logic                  last_q;
	logic [7:0]            q_q;
	logic                  cnt_en_q;
	logic [PC_ABITS-1:0]   addr_q;
	logic [KMER_BITS:0]    clr_q;
	logic [2:0]            step_q;

	// consensus accumulation
	logic [COUNT_BITS-1:0] best_q, total_q;
	logic [2:0]            nuc_q;

	// rank scan
	logic [KMER_BITS:0]    scan_q;
	logic                  rd_vld_s1;
	logic [KMER_BITS-1:0]  rd_k_s1;
	logic                  found_q, have_prev_q;
	logic [COUNT_BITS-1:0] bc_q, pc_q;
	logic [KMER_BITS-1:0]  bk_q, pk_q;
	logic [7:0]            rank_q;
	logic                  rhit_q;

	logic [8:0] limit;
	assign limit = (max_length_q > 9'(MAX_POSITIONS)) ? 9'(MAX_POSITIONS) : max_length_q;
	logic [TOP_BITS-1:0] keep;
	assign keep = (top_count_q > 7'(TOP_MAX)) ? TOP_BITS'(TOP_MAX) : TOP_BITS'(top_count_q);

	wire accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	logic [2:0] in_code;
	assign in_code = (base > BASE_N) ? BASE_N : base;

	// k-mer shift and N flag after the latched base
	logic [KMER_BITS-1:0] kshift_nx;
	logic                 khasn_nx;
	assign kshift_nx = (rpos_q < RPOS_BITS'(KMER_LEN)) ?
		{kshift_q[KMER_BITS-3:0], code_q[1:0]} : kshift_q;
	assign khasn_nx = khasn_q | ((rpos_q < RPOS_BITS'(KMER_LEN)) && (code_q == BASE_N));

	// pc address for a position and base
	function automatic logic [PC_ABITS-1:0] pc_addr(input logic [7:0] p, input logic [2:0] n);
		pc_addr = PC_ABITS'({p, 2'b00}) + PC_ABITS'(p) + PC_ABITS'(n);
	endfunction

	// memory drive
	always_comb begin
		pc_we = 1'b0;
		pc_waddr = addr_q;
		pc_wdata = sat_inc(pc_rdata);
		pc_raddr = addr_q;
		kh_we = 1'b0;
		kh_waddr = kshift_q;
		kh_wdata = sat_inc(kh_rdata);
		kh_raddr = kshift_q;
		case (state_q)
			ST_CLEAR: begin
				kh_we = 1'b1;
				kh_waddr = clr_q[KMER_BITS-1:0];
				kh_wdata = '0;
				pc_we = (clr_q < (KMER_BITS+1)'(PC_DEPTH));
				pc_waddr = clr_q[PC_ABITS-1:0];
				pc_wdata = '0;
			end
			ST_BWR: pc_we = cnt_en_q;
			ST_KWR: kh_we = 1'b1;
			ST_CRD: pc_raddr = pc_addr(q_q, step_q);
			ST_SCAN: kh_raddr = scan_q[KMER_BITS-1:0];
			default: ;
		endcase
	end

	wire [COUNT_BITS-1:0] sc = kh_rdata;
	wire cand_ok = rd_vld_s1 && (sc != '0) &&
		(!have_prev_q || ranks_before(pc_q, pk_q, sc, rd_k_s1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			rpos_q <= '0;
			kshift_q <= '0;
			khasn_q <= 1'b0;
			obs_len_q <= '0;
			ksum_q <= '0;
			out_valid <= 1'b0;
			rd_vld_s1 <= 1'b0;
			code_q <= '0;
			last_q <= 1'b0;
			q_q <= '0;
			step_q <= '0;
			cnt_en_q <= 1'b0;
			addr_q <= '0;
			best_q <= '0;
			total_q <= '0;
			nuc_q <= '0;
			scan_q <= '0;
			rd_k_s1 <= '0;
			found_q <= 1'b0;
			have_prev_q <= 1'b0;
			bc_q <= '0;
			pc_q <= '0;
			bk_q <= '0;
			pk_q <= '0;
			rank_q <= '0;
			rhit_q <= 1'b0;
		end else begin
			// output register: load a new result or drop a transferred one
			if (state_q == ST_OUT && (!out_valid || !out_stall))
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (KMER_BITS+1)'(KMER_SPACE - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: if (accept) begin
					code_q <= in_code;
					last_q <= read_end;
					q_q <= query_index;
					step_q <= '0;
					case (mode)
						MODE_BASE: begin
							cnt_en_q <= (rpos_q < RPOS_BITS'(limit));
							addr_q <= pc_addr(rpos_q[7:0], in_code);
							state_q <= ST_BRD;
						end
						MODE_CONS: begin
							best_q <= '0;
							total_q <= COUNT_BITS'(1);
							nuc_q <= BASE_N;
							if ({1'b0, query_index} < obs_len_q)
								state_q <= ST_CRD;
							else
								state_q <= ST_OUT;
						end
						MODE_RANK: begin
							rank_q <= '0;
							rhit_q <= 1'b0;
							have_prev_q <= 1'b0;
							found_q <= 1'b0;
							scan_q <= '0;
							if (TOP_BITS'(query_index) >= keep || query_index >= 8'(TOP_MAX))
								state_q <= ST_OUT;
							else
								state_q <= ST_SCAN;
						end
						default: ;
					endcase
				end
				ST_BRD: state_q <= ST_BWR;
				ST_BWR: begin
					if (cnt_en_q && (rpos_q + 1'b1 > RPOS_BITS'(obs_len_q)))
						obs_len_q <= LEN_BITS'(rpos_q + 1'b1);
					if (last_q) begin
						rpos_q <= '0;
						// leading k-mer complete and free of N: count it
						if ((rpos_q >= RPOS_BITS'(KMER_LEN - 1)) && !khasn_nx) begin
							kshift_q <= kshift_nx;
							state_q <= ST_KRD;
						end else begin
							kshift_q <= '0;
							khasn_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else begin
						kshift_q <= kshift_nx;
						khasn_q <= khasn_nx;
						if (rpos_q != '1)
							rpos_q <= rpos_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_KRD: state_q <= ST_KWR;
				ST_KWR: begin
					ksum_q <= sat_inc(ksum_q);
					kshift_q <= '0;
					khasn_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				// one count read per cycle, data in the next cycle
				ST_CRD: begin
					step_q <= step_q + 1'b1;
					if (step_q != 3'd0) begin
						total_q <= sat_add(total_q, pc_rdata);
						if (pc_rdata > best_q) begin
							best_q <= pc_rdata;
							nuc_q <= step_q - 1'b1;
						end else if (pc_rdata == best_q)
							nuc_q <= BASE_N;
					end
					if (step_q == 3'd4)
						state_q <= ST_OUT;
				end
				// rank pass: read one entry per cycle, compare in the next cycle
				ST_SCAN: begin
					rd_vld_s1 <= !scan_q[KMER_BITS];
					rd_k_s1 <= scan_q[KMER_BITS-1:0];
					if (!scan_q[KMER_BITS])
						scan_q <= scan_q + 1'b1;
					if (cand_ok && (!found_q || ranks_before(sc, rd_k_s1, bc_q, bk_q))) begin
						found_q <= 1'b1;
						bc_q <= sc;
						bk_q <= rd_k_s1;
					end
					if (scan_q[KMER_BITS] && !rd_vld_s1) begin
						if (!found_q)
							state_q <= ST_OUT;
						else begin
							have_prev_q <= 1'b1;
							pc_q <= bc_q;
							pk_q <= bk_q;
							found_q <= 1'b0;
							scan_q <= '0;
							if (rank_q == q_q) begin
								rhit_q <= 1'b1;
								state_q <= ST_OUT;
							end
							rank_q <= rank_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid || !out_stall)
						state_q <= ST_CWAIT;
				end
				ST_CWAIT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result fields, loaded when the output register takes a new result
	logic is_cons_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept)
			is_cons_q <= (mode == MODE_CONS);
		if (state_q == ST_OUT && (!out_valid || !out_stall)) begin
			if (is_cons_q) begin
				hit <= (step_q == 3'd5);
				consensus_base <= nuc_q;
				majority_count <= best_q;
				depth_total <= total_q;
				kmer_code <= '0;
				kmer_hits <= '0;
				kmer_total <= '0;
			end else begin
				hit <= rhit_q;
				consensus_base <= BASE_N;
				majority_count <= '0;
				depth_total <= '0;
				kmer_code <= rhit_q ? pk_q : '0;
				kmer_hits <= rhit_q ? pc_q : '0;
				kmer_total <= ksum_q;
			end
		end
	end
endmodule
`default_nettype wire
